FILE: rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared widths and constants for the shade color slot cache.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int COLOR_BITS  = 32;
	localparam int SLOT_BITS   = 4;
	localparam int VERTEX_BITS = 10;
	localparam int SHADE_BITS  = 24;
	localparam int CHAN_BITS   = 8;

	// grey level that every shade moves toward
	localparam int GREY_LEVEL = 192;

	typedef logic [COLOR_BITS-1:0] color_t;
	typedef logic [SHADE_BITS-1:0] shade_t;

	typedef struct packed {
		shade_t top;
		shade_t inner;
		shade_t outer;
	} shades_t;

endpackage

FILE: rtl/shade_color_slot_cache_core.sv
// ----------------------------------------------------------------------------
// shade_color_slot_cache_core
// Color slot cache with shade generation.
// ----------------------------------------------------------------------------
// Input channel color_valid/color_ready carries one 32-bit ARGB color a beat.
// Output channel result_valid/result_ready returns one result beat per color:
// hit, slot, start_vertex, fresh_buffer and three RGB shades toward grey.
// After a color is taken, one shared comparator scans the filled slots in
// order, one slot a cycle, through the registered read port of the slot
// memory. A hit stops the scan; a miss goes on to a write state that stores the
// color at the fill position (wrapping to slot zero when full).
// An empty cache skips the scan and goes straight to the write. color_ready is
// low meanwhile and rises with result_valid, so a new color is taken only once
// the result of the last one has been loaded into the output register.
// The result sits in an output register; while the receiver stalls it holds,
// and a following color may be taken and scanned, but its result waits until
// the register frees. Reset clears the fill count and control state; slot
// contents are only read once written, so the memory needs no clearing.
// ----------------------------------------------------------------------------
module shade_color_slot_cache_core #(
	parameter int CACHE_SLOTS       = 16,
	parameter int VERTICES_PER_SLOT = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        color_valid,
	output logic        color_ready,
	input  logic [31:0] color,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        hit,
	output logic [3:0]  slot,
	output logic [9:0]  start_vertex,
	output logic        fresh_buffer,
	output logic [23:0] top_shade,
	output logic [23:0] inner_shade,
	output logic [23:0] outer_shade
);

	localparam int SW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int FW = $clog2(CACHE_SLOTS + 1);
	localparam int VW = $clog2(VERTICES_PER_SLOT + 1);
	localparam int PW = SW + VW;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]      state_q;
	logic [FW-1:0]   fill_q;
	logic [FW-1:0]   addr_q;
	logic [FW-1:0]   cmp_idx_q;
	logic            cmp_vld_q;
	scs_pkg::color_t color_q;
	logic [SW-1:0]   slot_q;
	logic            hit_q;
	logic            fresh_q;

	scs_pkg::color_t  rd_data;
	scs_pkg::shades_t shades;

	logic            rd_en;
	logic            wr_en;
	logic            full;
	logic [SW-1:0]   wr_slot;
	logic            match;
	logic            last_cmp;
	logic            out_free;
	logic [PW-1:0]   prod;
	logic [PW+9:0]   prod_ext;
	logic [SW+3:0]   slot_ext;

	assign color_ready = (state_q == ST_IDLE);
	assign full        = (fill_q >= FW'(CACHE_SLOTS));
	assign wr_slot     = full ? '0 : fill_q[SW-1:0];
	assign rd_en       = (state_q == ST_SCAN) && (addr_q < fill_q);
	assign wr_en       = (state_q == ST_WRITE);
	assign match       = cmp_vld_q && (rd_data == color_q);
	assign last_cmp    = cmp_vld_q && (cmp_idx_q == FW'(fill_q - 1'b1));
	assign out_free    = !result_valid || result_ready;

	assign prod     = PW'(slot_q) * PW'(VERTICES_PER_SLOT);
	assign prod_ext = {10'b0, prod};
	assign slot_ext = {4'b0, slot_q};

	scs_store #(
		.DEPTH (CACHE_SLOTS),
		.AW    (SW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_slot),
		.wr_data (color_q),
		.rd_en   (rd_en),
		.rd_addr (addr_q[SW-1:0]),
		.rd_data (rd_data)
	);

	scs_shade u_shade (
		.rgb    (color_q[23:0]),
		.shades (shades)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			addr_q    <= '0;
			cmp_idx_q <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					addr_q    <= '0;
					cmp_vld_q <= 1'b0;
					if (color_valid) begin
						state_q <= (fill_q == '0) ? ST_WRITE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// read of slot addr_q overlaps compare of slot addr_q-1
					cmp_vld_q <= rd_en;
					cmp_idx_q <= addr_q;
					if (rd_en) begin
						addr_q <= addr_q + 1'b1;
					end
					if (match) begin
						state_q <= ST_DONE;
					end else if (last_cmp) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					fill_q  <= full ? FW'(1) : FW'(fill_q + 1'b1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (color_valid && color_ready) begin
			color_q <= color;
		end
		if (state_q == ST_SCAN && match) begin
			slot_q  <= cmp_idx_q[SW-1:0];
			hit_q   <= 1'b1;
			fresh_q <= 1'b0;
		end else if (state_q == ST_WRITE) begin
			slot_q  <= wr_slot;
			hit_q   <= 1'b0;
			fresh_q <= (wr_slot == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			hit          <= hit_q;
			slot         <= slot_ext[3:0];
			start_vertex <= prod_ext[9:0];
			fresh_buffer <= fresh_q;
			top_shade    <= shades.top;
			inner_shade  <= shades.inner;
			outer_shade  <= shades.outer;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CACHE_SLOTS))
		else $error("fill count beyond cache depth");

	a_hit_not_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && hit |-> !fresh_buffer)
		else $error("hit flagged as fresh buffer");

	a_fresh_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fresh_buffer |-> slot == 4'd0)
		else $error("fresh buffer away from slot zero");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid && color_ready |=> !color_ready)
		else $error("accepted a beat while busy");

	a_write_fills: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |=> fill_q != '0)
		else $error("fill count empty after write");

endmodule

FILE: rtl/scs_store.sv
// ----------------------------------------------------------------------------
// scs_store
// Slot color memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scs_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  scs_pkg::color_t       wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output scs_pkg::color_t       rd_data
);

	scs_pkg::color_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/scs_shade.sv
// ----------------------------------------------------------------------------
// scs_shade
// Per-channel shades of an RGB color toward grey, truncating division.
// ----------------------------------------------------------------------------
module scs_shade (
	input  logic [23:0]      rgb,
	output scs_pkg::shades_t shades
);

	localparam logic signed [9:0] GREY = 10'(scs_pkg::GREY_LEVEL);

	// 192 + (c - 192) / 8
	function automatic logic [7:0] top_ch(input logic [7:0] c);
		logic signed [9:0] d;
		logic signed [9:0] q;
		logic signed [9:0] s;
		d = $signed({2'b00, c}) - GREY;
		q = (d + (d[9] ? 10'sd7 : 10'sd0)) >>> 3;
		s = GREY + q;
		return s[7:0];
	endfunction

	// c + (192 - c) / 4 when quarter is set, else / 2, truncated toward zero
	function automatic logic [7:0] grey_ch(input logic [7:0] c, input logic quarter);
		logic signed [9:0] e;
		logic signed [9:0] q;
		logic signed [9:0] s;
		e = GREY - $signed({2'b00, c});
		if (quarter) begin
			q = (e + (e[9] ? 10'sd3 : 10'sd0)) >>> 2;
		end else begin
			q = (e + (e[9] ? 10'sd1 : 10'sd0)) >>> 1;
		end
		s = $signed({2'b00, c}) + q;
		return s[7:0];
	endfunction

	always_comb begin
		shades.top   = {top_ch(rgb[23:16]), top_ch(rgb[15:8]), top_ch(rgb[7:0])};
		shades.inner = {grey_ch(rgb[23:16], 1'b1), grey_ch(rgb[15:8], 1'b1),
			grey_ch(rgb[7:0], 1'b1)};
		shades.outer = {grey_ch(rgb[23:16], 1'b0), grey_ch(rgb[15:8], 1'b0),
			grey_ch(rgb[7:0], 1'b0)};
	end

endmodule

FILE: verif/scs_checker.sv
// ----------------------------------------------------------------------------
// scs_checker
// Watches both channels of the shade color slot cache and checks every result.
// Each accepted color goes through a slot lookup and shade calculation kept
// here. The result is queued, and each result beat is compared field by field
// against the oldest queued result.
// ----------------------------------------------------------------------------
module scs_checker #(
	parameter int CACHE_SLOTS       = 16,
	parameter int VERTICES_PER_SLOT = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        color_valid,
	input  logic        color_ready,
	input  logic [31:0] color,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic        hit,
	input  logic [3:0]  slot,
	input  logic [9:0]  start_vertex,
	input  logic        fresh_buffer,
	input  logic [23:0] top_shade,
	input  logic [23:0] inner_shade,
	input  logic [23:0] outer_shade,
	output int          errors,
	output int          pending,
	output int          hits,
	output int          misses,
	output int          wraps
);

	typedef struct {
		logic            hit;
		logic [3:0]      slot;
		logic [9:0]      start_vertex;
		logic            fresh;
		scs_pkg::shade_t top;
		scs_pkg::shade_t inner;
		scs_pkg::shade_t outer;
	} slot_result_t;

	scs_pkg::color_t cached_colors [CACHE_SLOTS];
	int              filled;
	slot_result_t    expected_results [$];

	initial begin
		errors  = 0;
		pending = 0;
		hits    = 0;
		misses  = 0;
		wraps   = 0;
		filled  = 0;
	end

	// int division truncates toward zero, same as the channel math wants
	function automatic logic [7:0] top_chan(int c);
		return 8'(scs_pkg::GREY_LEVEL + (c - scs_pkg::GREY_LEVEL) / 8);
	endfunction

	function automatic logic [7:0] grey_chan(int c, int divisor);
		return 8'(c + (scs_pkg::GREY_LEVEL - c) / divisor);
	endfunction

	task automatic lookup_color(input scs_pkg::color_t c);
		slot_result_t r;
		int found;
		int chan [3];
		found = -1;
		for (int i = 0; i < filled && i < CACHE_SLOTS; i++)
			if (found < 0 && cached_colors[i] == c)
				found = i;
		r.hit   = (found >= 0);
		r.fresh = 1'b0;
		if (found < 0) begin
			// full cache drops every slot and restarts at zero
			if (filled >= CACHE_SLOTS) begin
				filled = 0;
				wraps++;
			end
			found = filled;
			cached_colors[found] = c;
			r.fresh = (found == 0);
			filled++;
			misses++;
		end else begin
			hits++;
		end
		r.slot         = 4'(found);
		r.start_vertex = 10'(found * VERTICES_PER_SLOT);
		for (int k = 0; k < 3; k++)
			chan[k] = int'(c[8*k +: 8]);
		r.top   = {top_chan(chan[2]), top_chan(chan[1]), top_chan(chan[0])};
		r.inner = {grey_chan(chan[2], 4), grey_chan(chan[1], 4), grey_chan(chan[0], 4)};
		r.outer = {grey_chan(chan[2], 2), grey_chan(chan[1], 2), grey_chan(chan[0], 2)};
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_result_t e;
		if (!arst_n) begin
			filled = 0;
			expected_results.delete();
		end else begin
			if (color_valid && color_ready)
				lookup_color(color);
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no color outstanding");
					errors++;
				end else begin
					e = expected_results.pop_front();
					compare_field("hit", 32'(e.hit), 32'(hit));
					compare_field("slot", 32'(e.slot), 32'(slot));
					compare_field("start_vertex", 32'(e.start_vertex), 32'(start_vertex));
					compare_field("fresh_buffer", 32'(e.fresh), 32'(fresh_buffer));
					compare_field("top_shade", 32'(e.top), 32'(top_shade));
					compare_field("inner_shade", 32'(e.inner), 32'(inner_shade));
					compare_field("outer_shade", 32'(e.outer), 32'(outer_shade));
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for shade_color_slot_cache_core.
// Sends a directed color list (hits, alpha-only differences, shade rounding
// around grey, full-cache wrap) and then palette-driven random colors so hits,
// misses and wraps all recur, under three mixes of sender and receiver idling.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CACHE_SLOTS       = 16;
	localparam int VERTICES_PER_SLOT = 50;
	localparam int PHASE_ITEMS       = 450;
	localparam int DRAIN_CYCLES      = CACHE_SLOTS + 8;
	localparam int STALL_LIMIT       = 2000;
	localparam int N_DIRECTED        = 22;
	localparam int PALETTE_MAX       = 24;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        color_valid  = 1'b0;
	logic        color_ready;
	logic [31:0] color        = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        hit;
	logic [3:0]  slot;
	logic [9:0]  start_vertex;
	logic        fresh_buffer;
	logic [23:0] top_shade;
	logic [23:0] inner_shade;
	logic [23:0] outer_shade;

	int errors;
	int pending;
	int hits;
	int misses;
	int wraps;

	int              send_idle_pct = 8;
	int              recv_idle_pct = 70;
	int              sent          = 0;
	int              stall_cycles  = 0;
	scs_pkg::color_t directed_colors [N_DIRECTED];
	scs_pkg::color_t palette [PALETTE_MAX];

	always #5 clk = ~clk;

	shade_color_slot_cache_core #(
		.CACHE_SLOTS      (CACHE_SLOTS),
		.VERTICES_PER_SLOT(VERTICES_PER_SLOT)
	) dut (
		.clk, .arst_n, .color_valid, .color_ready, .color,
		.result_valid, .result_ready, .hit, .slot, .start_vertex, .fresh_buffer,
		.top_shade, .inner_shade, .outer_shade
	);

	scs_checker #(
		.CACHE_SLOTS      (CACHE_SLOTS),
		.VERTICES_PER_SLOT(VERTICES_PER_SLOT)
	) u_check (.*);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// no beat on either channel for too long means the block is stuck
	always @(posedge clk) begin
		if (arst_n) begin
			if ((color_valid && color_ready) || (result_valid && result_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat in %0d cycles", STALL_LIMIT);
				$display("FAIL shade_color_slot_cache_core");
				$finish;
			end
		end
	end

	task automatic send_color(input scs_pkg::color_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			color_valid <= 1'b0;
			@(posedge clk);
		end
		color_valid <= 1'b1;
		color       <= c;
		@(posedge clk);
		while (!color_ready)
			@(posedge clk);
		sent++;
	endtask

	// some entries are one bit away from an earlier one to stress exact compare
	task automatic refresh_palette(input int n);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(3) == 0)
				palette[i] = palette[$urandom_range(i - 1)] ^ (32'h1 << $urandom_range(31));
			else
				palette[i] = $urandom();
		end
	endtask

	initial begin
		int n_colors;
		int run_len;
		directed_colors = '{
			32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF,
			32'h80C0C0C0, 32'h7FC0C0C0,  // alpha-only difference
			32'h00BFC1B8, 32'h00C7B9C9,  // truncation just around grey
			32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'hFF000000,
			32'h00010203, 32'h00FEFDFC, 32'h12345678, 32'h87654321,
			32'hA5A5A5A5, 32'h5A5A5A5A,  // cache now full
			32'h5A5A5A5A,                // hit on the last slot
			32'hC3C3C3C3,                // wrap to slot zero
			32'hFFFFFFFF,                // dropped by the wrap
			32'hC3C3C3C3
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 70 : 0;
			recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 8 : 0;
			if (phase == 0)
				for (int i = 0; i < N_DIRECTED; i++)
					send_color(directed_colors[i]);
			while (sent < (phase + 1) * PHASE_ITEMS) begin
				// mostly fits in the cache; sometimes overflows to force wraps
				n_colors = ($urandom_range(3) == 0) ? $urandom_range(CACHE_SLOTS + 1, PALETTE_MAX)
					: $urandom_range(1, CACHE_SLOTS);
				refresh_palette(n_colors);
				run_len = $urandom_range(8, 40);
				for (int j = 0; j < run_len; j++) begin
					if ($urandom_range(9) < 8)
						send_color(palette[$urandom_range(n_colors - 1)]);
					else
						send_color($urandom());
				end
			end
		end
		color_valid <= 1'b0;

		// let the checker log the last accepted beat before polling
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d colors across three sender/receiver idle mixes", sent);
		$display("%0d hits, %0d misses, %0d full-cache wraps to slot zero",
			hits, misses, wraps);
		if (errors == 0 && pending == 0)
			$display("PASS shade_color_slot_cache_core");
		else
			$display("FAIL shade_color_slot_cache_core");
		$finish;
	end

endmodule
